### sv/bws_pkg.sv
// Shared types, constants and saturating helpers for binned_weight_statistics.
// Used by bws_unit, bws_ram users and the top level; depends on nothing.
package bws_pkg;

  localparam int NUM_BINS_DEF = 100;
  localparam logic [31:0] MIN_QUERY_COUNT = 32'd21;

  localparam logic [31:0] LOWER_RST = 32'd0;
  localparam logic [31:0] UPPER_RST = 32'd1048576;
  localparam logic        HIST_RST  = 1'b1;
  localparam logic [31:0] INIT_RST  = 32'd0;
  localparam logic [15:0] GAIN_RST  = 16'd563;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LOWER = 3'd0;
  localparam logic [2:0] REG_UPPER = 3'd1;
  localparam logic [2:0] REG_HIST  = 3'd2;
  localparam logic [2:0] REG_INIT  = 3'd3;
  localparam logic [2:0] REG_GAIN  = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RATIO_W, S_MEAN_W, S_HC, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_WB,
    S_Q_MEAN_W, S_Q_VAR_W, S_Q_SQRT_W, S_G0, S_G1, S_G2, S_G3, S_OUT
  } state_t;

  typedef struct packed {
    logic        func;
    logic [31:0] weight;
    logic [31:0] divisor;
    logic [16:0] position;
    logic [31:0] fallback;
  } in_item_t;

  typedef struct packed {
    logic        new_extreme;
    logic [31:0] estimate_out;
    logic [31:0] below_count;
    logic [31:0] above_count;
    logic [31:0] sample_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] sum;
    logic [63:0] spread;
    logic [31:0] hcount;
    logic [47:0] hsum;
    logic [31:0] pcount;
    logic [31:0] peak;
  } bin_rec_t;

  localparam int REC_W = $bits(bin_rec_t);

  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [6:0]  iters;
    logic [79:0] operand;
    logic [31:0] divisor;
  } unit_req_t;

  function automatic logic [31:0] inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic logic [63:0] add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

### sv/bws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/bws_unit.sv
// Shared shift-subtract unit: restoring division (one quotient bit a cycle)
// or integer square root (one root bit a cycle). Depends on bws_pkg.
module bws_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  bws_pkg::unit_req_t req,
  output logic               done,
  output logic [63:0]        result
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic [79:0] opnd_r, opnd_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [31:0] div_r, div_nxt;
  logic [42:0] sub_a, sub_b;
  logic [43:0] diff;
  logic        ge;

  always_comb begin
    sub_a = sqrt_r ? {rem_r, opnd_r[79:78]} : {10'b0, rem_r[31:0], opnd_r[79]};
    sub_b = sqrt_r ? {1'b0, q_r[39:0], 2'b01} : {11'b0, div_r};
    diff  = {1'b0, sub_a} - {1'b0, sub_b};
    ge    = !diff[43];

    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    opnd_nxt = opnd_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    div_nxt  = div_r;

    if (req.start) begin
      cnt_nxt  = req.iters;
      sqrt_nxt = req.is_sqrt;
      opnd_nxt = req.operand;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (cnt_r != 7'd0) begin
      // one step: keep the difference where it did not borrow
      rem_nxt  = ge ? diff[40:0] : sub_a[40:0];
      opnd_nxt = sqrt_r ? {opnd_r[77:0], 2'b00} : {opnd_r[78:0], 1'b0};
      q_nxt    = {q_r[62:0], ge};
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    sqrt_r <= sqrt_nxt;
    opnd_r <= opnd_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    div_r  <= div_nxt;
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

### sv/binned_weight_statistics.sv
// Top level of binned_weight_statistics: sequencer, statistics, bin store.
// Depends on bws_pkg, bws_unit and bws_ram.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. func 0
//   includes a sample: the ratio weight/divisor updates the running minimum,
//   maximum and limit counters, and with the histogram on the selected bin
//   accumulates the weight. func 1 queries a bin: if the histogram is on and
//   n exceeds 21, mean + gain*sqrt(spread/(n-1)), else the fallback. busy
//   stays high until the request is done. Each request gives one result on
//   out_data, marked by a one-cycle out_valid strobe; the receiver cannot
//   stall, so nothing waits. An include runs one division with the histogram
//   off and two with it on; a full query runs two divisions and a square
//   root; a fallback query does not use the unit. The shared shift-subtract
//   unit yields one quotient or root bit per cycle (48 bits of ratio, 48 of
//   mean, 64 of variance, 40 of root). The next request may be taken in
//   the cycle the strobe is shown.
//   Configuration is an APB-style port, register i at byte address 4*i;
//   pready is always high. Writing initial_sum clears every bin at once.
//   Reset restores register defaults, clears counters and marks all bins
//   empty; an empty bin reads as its cleared pattern, so no sweep is needed.
module binned_weight_statistics #(
  parameter int NUM_BINS = bws_pkg::NUM_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bws_pkg::in_item_t   in_data,
  output logic                out_valid,
  output bws_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int PROD_W = 17 + $clog2(NUM_BINS + 1);

  bws_pkg::state_t    state_r, state_nxt;
  bws_pkg::in_item_t  item_r, item_nxt;
  bws_pkg::out_item_t out_r, out_nxt;
  bws_pkg::bin_rec_t  rec_r, rec_nxt, rd_rec, clr_rec;
  bws_pkg::unit_req_t req;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] lower_r, lower_nxt, upper_r, upper_nxt, init_r, init_nxt;
  logic        hist_r, hist_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [31:0] min_r, min_nxt, max_r, max_nxt;
  logic [31:0] seen_r, seen_nxt, low_r, low_nxt, high_r, high_nxt;
  logic [NUM_BINS-1:0] valid_r, valid_nxt;
  logic [BIN_W-1:0] idx_r, idx_nxt, idx_in, ram_raddr;
  logic [47:0] mean_r, mean_nxt, dev_r, dev_nxt;
  logic [39:0] sd_r, sd_nxt;
  logic [79:0] acc_r, acc_nxt;
  logic [63:0] prod_r;
  logic [31:0] mul_a, mul_b;
  logic [31:0] est_r, est_nxt;
  logic        ext_r, ext_nxt;
  logic [PROD_W-1:0]    pos_prod;
  logic [PROD_W-17:0]   pos_bin;
  logic        unit_done;
  logic [63:0] unit_q;
  logic        ram_we;
  logic [bws_pkg::REC_W-1:0] ram_rdata;
  logic        cfg_wr;
  logic [31:0] ratio;
  logic [47:0] w48, mean_q;
  logic [63:0] sq;
  logic [48:0] est_sum;

  // bin select: floor(NUM_BINS * position / 2^16), clamp to the last bin
  always_comb begin
    pos_prod = PROD_W'(NUM_BINS) * PROD_W'(in_data.position);
    pos_bin  = pos_prod[PROD_W-1:16];
    idx_in   = (pos_bin >= (PROD_W-16)'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
                                                   : pos_bin[BIN_W-1:0];
  end

  assign ram_raddr = (state_r == bws_pkg::S_IDLE) ? idx_in : idx_r;

  bws_ram #(.WIDTH(bws_pkg::REC_W), .DEPTH(NUM_BINS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (rec_nxt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bws_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .done   (unit_done),
    .result (unit_q)
  );

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      bws_pkg::REG_LOWER: prdata = lower_r;
      bws_pkg::REG_UPPER: prdata = upper_r;
      bws_pkg::REG_HIST:  prdata = {31'b0, hist_r};
      bws_pkg::REG_INIT:  prdata = init_r;
      bws_pkg::REG_GAIN:  prdata = {16'b0, gain_r};
      default:            prdata = 32'b0;
    endcase
  end

  always_comb begin
    clr_rec = '{count: 32'd1, sum: {16'b0, init_r}, spread: {32'b0, init_r},
                hcount: 32'd1, hsum: {16'b0, init_r}, pcount: 32'd1, peak: init_r};
    rd_rec  = valid_r[idx_r] ? bws_pkg::bin_rec_t'(ram_rdata) : clr_rec;
    w48     = {16'b0, item_r.weight};
    ratio   = (unit_q[47:32] != 16'b0) ? 32'hFFFF_FFFF : unit_q[31:0];
    mean_q  = unit_q[47:0];
    sq      = (dev_r[47:40] != 8'b0) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_r[79:16];
    est_sum = {1'b0, mean_r} + {1'b0, acc_r[55:8]};

    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    hist_nxt      = hist_r;
    init_nxt      = init_r;
    gain_nxt      = gain_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    seen_nxt      = seen_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    rec_nxt       = rec_r;
    mean_nxt      = mean_r;
    dev_nxt       = dev_r;
    sd_nxt        = sd_r;
    acc_nxt       = acc_r;
    est_nxt       = est_r;
    ext_nxt       = ext_r;
    mul_a         = 32'b0;
    mul_b         = 32'b0;
    ram_we        = 1'b0;
    req           = '0;

    // the user must issue configuration writes only while idle; the block does not enforce it
    if (cfg_wr) begin
      unique case (paddr[4:2])
        bws_pkg::REG_LOWER: begin
          lower_nxt = pwdata;
          max_nxt   = pwdata;
        end
        bws_pkg::REG_UPPER: begin
          upper_nxt = pwdata;
          min_nxt   = pwdata;
        end
        bws_pkg::REG_HIST: hist_nxt = pwdata[0];
        bws_pkg::REG_INIT: begin
          init_nxt  = pwdata;
          valid_nxt = '0;
        end
        bws_pkg::REG_GAIN: gain_nxt = pwdata[15:0];
        default: ;
      endcase
    end

    unique case (state_r)
      bws_pkg::S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          idx_nxt   = idx_in;
          est_nxt   = 32'b0;
          ext_nxt   = 1'b0;
          state_nxt = bws_pkg::S_LOAD;
        end
      end
      bws_pkg::S_LOAD: begin
        rec_nxt = rd_rec;
        if (!item_r.func) begin
          // fold count, sum and peak now; start the ratio division
          rec_nxt.count = bws_pkg::inc32(rd_rec.count);
          rec_nxt.sum   = bws_pkg::add48(rd_rec.sum, w48);
          if (rd_rec.peak < item_r.weight) begin
            rec_nxt.pcount = bws_pkg::inc32(rd_rec.pcount);
            rec_nxt.peak   = item_r.weight;
          end
          req = '{start: 1'b1, is_sqrt: 1'b0, iters: 7'd48,
                  operand: {item_r.weight, 48'b0}, divisor: item_r.divisor};
          state_nxt = bws_pkg::S_RATIO_W;
        end else if (hist_r && (rd_rec.count > bws_pkg::MIN_QUERY_COUNT)) begin
          req = '{start: 1'b1, is_sqrt: 1'b0, iters: 7'd48,
                  operand: {rd_rec.sum, 32'b0}, divisor: rd_rec.count};
          state_nxt = bws_pkg::S_Q_MEAN_W;
        end else begin
          est_nxt   = item_r.fallback;
          state_nxt = bws_pkg::S_OUT;
        end
      end
      bws_pkg::S_RATIO_W: begin
        if (unit_done) begin
          seen_nxt = bws_pkg::inc32(seen_r);
          if (ratio < min_r) begin
            min_nxt = ratio;
            ext_nxt = 1'b1;
          end
          if (ratio > max_r) begin
            max_nxt = ratio;
            ext_nxt = 1'b1;
          end
          if (ratio < lower_r) low_nxt = bws_pkg::inc32(low_r);
          if (ratio > upper_r) high_nxt = bws_pkg::inc32(high_r);
          if (hist_r) begin
            req = '{start: 1'b1, is_sqrt: 1'b0, iters: 7'd48,
                    operand: {rec_r.sum, 32'b0}, divisor: rec_r.count};
            state_nxt = bws_pkg::S_MEAN_W;
          end else begin
            state_nxt = bws_pkg::S_OUT;
          end
        end
      end
      bws_pkg::S_MEAN_W: begin
        if (unit_done) begin
          dev_nxt   = (w48 > mean_q) ? w48 - mean_q : mean_q - w48;
          state_nxt = bws_pkg::S_HC;
        end
      end
      bws_pkg::S_HC: begin
        mul_a     = item_r.weight;
        mul_b     = rec_r.hcount;
        state_nxt = bws_pkg::S_SQ0;
      end
      bws_pkg::S_SQ0: begin
        if ({16'b0, rec_r.hsum} < prod_r) begin
          rec_nxt.hcount = bws_pkg::inc32(rec_r.hcount);
          rec_nxt.hsum   = bws_pkg::add48(rec_r.hsum, w48);
        end
        mul_a     = {12'b0, dev_r[19:0]};
        mul_b     = {12'b0, dev_r[19:0]};
        state_nxt = bws_pkg::S_SQ1;
      end
      bws_pkg::S_SQ1: begin
        acc_nxt   = {16'b0, prod_r};
        mul_a     = {12'b0, dev_r[39:20]};
        mul_b     = {12'b0, dev_r[19:0]};
        state_nxt = bws_pkg::S_SQ2;
      end
      bws_pkg::S_SQ2: begin
        acc_nxt   = acc_r + (80'(prod_r) << 21);
        mul_a     = {12'b0, dev_r[39:20]};
        mul_b     = {12'b0, dev_r[39:20]};
        state_nxt = bws_pkg::S_SQ3;
      end
      bws_pkg::S_SQ3: begin
        acc_nxt   = acc_r + (80'(prod_r) << 40);
        state_nxt = bws_pkg::S_WB;
      end
      bws_pkg::S_WB: begin
        rec_nxt.spread   = bws_pkg::add64(rec_r.spread, sq);
        ram_we           = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        state_nxt        = bws_pkg::S_OUT;
      end
      bws_pkg::S_Q_MEAN_W: begin
        if (unit_done) begin
          mean_nxt = mean_q;
          req = '{start: 1'b1, is_sqrt: 1'b0, iters: 7'd64,
                  operand: {rec_r.spread, 16'b0}, divisor: rec_r.count - 32'd1};
          state_nxt = bws_pkg::S_Q_VAR_W;
        end
      end
      bws_pkg::S_Q_VAR_W: begin
        if (unit_done) begin
          req = '{start: 1'b1, is_sqrt: 1'b1, iters: 7'd40,
                  operand: {unit_q, 16'b0}, divisor: 32'b0};
          state_nxt = bws_pkg::S_Q_SQRT_W;
        end
      end
      bws_pkg::S_Q_SQRT_W: begin
        if (unit_done) begin
          sd_nxt    = unit_q[39:0];
          state_nxt = bws_pkg::S_G0;
        end
      end
      bws_pkg::S_G0: begin
        mul_a     = {16'b0, gain_r};
        mul_b     = {12'b0, sd_r[19:0]};
        state_nxt = bws_pkg::S_G1;
      end
      bws_pkg::S_G1: begin
        acc_nxt   = {16'b0, prod_r};
        mul_a     = {16'b0, gain_r};
        mul_b     = {12'b0, sd_r[39:20]};
        state_nxt = bws_pkg::S_G2;
      end
      bws_pkg::S_G2: begin
        acc_nxt   = acc_r + (80'(prod_r) << 20);
        state_nxt = bws_pkg::S_G3;
      end
      bws_pkg::S_G3: begin
        est_nxt   = (est_sum[48:32] != 17'b0) ? 32'hFFFF_FFFF : est_sum[31:0];
        state_nxt = bws_pkg::S_OUT;
      end
      bws_pkg::S_OUT: begin
        out_nxt = '{new_extreme: ext_r, estimate_out: est_r, below_count: low_r,
                    above_count: high_r, sample_count: seen_r};
        out_valid_nxt = 1'b1;
        state_nxt     = bws_pkg::S_IDLE;
      end
      default: state_nxt = bws_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bws_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      lower_r     <= bws_pkg::LOWER_RST;
      upper_r     <= bws_pkg::UPPER_RST;
      hist_r      <= bws_pkg::HIST_RST;
      init_r      <= bws_pkg::INIT_RST;
      gain_r      <= bws_pkg::GAIN_RST;
      min_r       <= bws_pkg::UPPER_RST;
      max_r       <= bws_pkg::LOWER_RST;
      seen_r      <= '0;
      low_r       <= '0;
      high_r      <= '0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      hist_r      <= hist_nxt;
      init_r      <= init_nxt;
      gain_r      <= gain_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      seen_r      <= seen_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      valid_r     <= valid_nxt;
    end
    item_r <= item_nxt;
    out_r  <= out_nxt;
    idx_r  <= idx_nxt;
    rec_r  <= rec_nxt;
    mean_r <= mean_nxt;
    dev_r  <= dev_nxt;
    sd_r   <= sd_nxt;
    acc_r  <= acc_nxt;
    est_r  <= est_nxt;
    ext_r  <= ext_nxt;
  end

  assign busy      = (state_r != bws_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted request did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> (state_r == bws_pkg::S_RATIO_W || state_r == bws_pkg::S_MEAN_W ||
                   state_r == bws_pkg::S_Q_MEAN_W || state_r == bws_pkg::S_Q_VAR_W ||
                   state_r == bws_pkg::S_Q_SQRT_W))
    else $error("shared unit finished outside a wait state");

  a_wb_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ##2 out_valid) else $error("bin write-back not followed by result");
`endif

endmodule
